/* design/fgs_pkg.sv */
// fgs_pkg: shared constants, status codes and control structs of the
// FAT32 geometry solver. No dependencies.
package fgs_pkg;

    // defaults for the top-level parameters
    localparam int unsigned RESERVED_SECTORS_DEF  = 32;
    localparam int unsigned MAX_CLUSTER_BYTES_DEF = 32768;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // FAT32 cluster count window
    localparam logic [31:0] MIN_CLUSTERS = 32'd65525;
    localparam logic [31:0] MAX_CLUSTERS = 32'h0fff_ffee;

    // FAT length search bounds fit 26 bits; one spare
    localparam int unsigned SEARCH_W = 27;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, pre-check result, first size
        logic calc_hi;    // upper FAT length bound for current size
        logic init_lo;    // lower bound = 1
        logic calc_mid;   // midpoint of bounds
        logic step;       // narrow bounds by the midpoint test
        logic next_size;  // double cluster size
        logic take_ok;    // write a good layout to the result register
        logic take_fail;  // write an error result
    } fgs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] pre_status;  // argument check of the word at the input
        logic       size_fits;   // cluster bytes within limit
        logic       hi_skip;     // largest FAT leaves no data area
        logic       search_done; // lo >= hi
        logic       clus_ok;     // cluster count within FAT32 window
    } fgs_stat_t;

endpackage

/* design/fgs_datapath.sv */
// fgs_datapath: request registers, FAT length binary search and result
// register of the geometry solver. Depends on fgs_pkg.
module fgs_datapath #(
    parameter int unsigned RESERVED_SECTORS  = fgs_pkg::RESERVED_SECTORS_DEF,
    parameter int unsigned MAX_CLUSTER_BYTES = fgs_pkg::MAX_CLUSTER_BYTES_DEF
) (
    input  logic             aclk,
    input  logic [63:0]      s_total,
    input  logic [15:0]      s_bps,
    input  logic [63:0]      s_hidden,
    input  fgs_pkg::fgs_cmd_t  cmd,
    output fgs_pkg::fgs_stat_t stat,
    output logic [1:0]       res_status,
    output logic [6:0]       res_spc,
    output logic [31:0]      res_fat,
    output logic [27:0]      res_clus,
    output logic [31:0]      res_data
);
    import fgs_pkg::*;

    localparam logic [33:0] RSV = 34'(RESERVED_SECTORS);
    localparam logic [19:0] MCB = 20'(MAX_CLUSTER_BYTES);

    logic [31:0]         total_reg;
    logic [3:0]          k_reg;      // log2 of bytes per sector
    logic [2:0]          s_reg;      // log2 of sectors per cluster
    logic [1:0]          err_reg;
    logic [SEARCH_W-1:0] lo_reg, hi_reg, mid_reg;
    logic [1:0]          status_reg;
    logic [6:0]          spc_reg;
    logic [31:0]         fat_reg;
    logic [27:0]         clus_reg;
    logic [31:0]         data_reg;

    logic [3:0]          k_in;
    logic                bps_ok;
    logic                total_bad;
    logic [1:0]          pre_status;
    logic [34:0]         q_val, t_val;
    logic [SEARCH_W-1:0] hi_calc, mid_calc;
    logic [33:0]         c_val, data_val, clus_val;
    logic [37:0]         entries;
    logic                ent_hit;
    logic [19:0]         size_val;

    // argument check on the incoming word
    always_comb begin
        bps_ok = 1'b1;
        case (s_bps)
            16'd512:  k_in = 4'd9;
            16'd1024: k_in = 4'd10;
            16'd2048: k_in = 4'd11;
            16'd4096: k_in = 4'd12;
            default: begin
                k_in   = 4'd9;
                bps_ok = 1'b0;
            end
        endcase
        total_bad = (s_total[63:32] != 32'd0) || ({2'b0, s_total[31:0]} <= RSV);
        if (!bps_ok || total_bad) begin
            pre_status = ST_INVALID;
        end else if (s_hidden[63:32] != 32'd0) begin
            pre_status = ST_OVERFLOW;
        end else begin
            pre_status = ST_OK;
        end
    end

    // hi = ((total/spc + 2) * 4 + bps - 1) / bps
    assign q_val   = {3'b0, total_reg} >> s_reg;
    assign t_val   = ((q_val + 35'd2) << 2) + ((35'd1 << k_reg) - 35'd1);
    assign hi_calc = SEARCH_W'(t_val >> k_reg);

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    // clusters left beside a FAT of mid sectors vs. entries it holds
    assign c_val   = ({2'b0, total_reg} - RSV - {6'b0, mid_reg, 1'b0}) >> s_reg;
    assign entries = {11'b0, mid_reg} << (k_reg - 4'd2);
    assign ent_hit = entries >= ({4'b0, c_val} + 38'd2);

    assign data_val = RSV + {6'b0, lo_reg, 1'b0};
    assign clus_val = ({2'b0, total_reg} - data_val) >> s_reg;

    assign size_val = 20'd1 << (5'(s_reg) + 5'(k_reg));

    assign stat.pre_status  = pre_status;
    assign stat.size_fits   = size_val <= MCB;
    assign stat.hi_skip     = (RSV + {6'b0, hi_reg, 1'b0}) >= {2'b0, total_reg};
    assign stat.search_done = lo_reg >= hi_reg;
    assign stat.clus_ok     = (clus_val >= 34'(MIN_CLUSTERS))
                           && (clus_val <= 34'(MAX_CLUSTERS));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            total_reg <= s_total[31:0];
            k_reg     <= k_in;
            s_reg     <= 3'd0;
            err_reg   <= pre_status;
        end
        if (cmd.calc_hi) begin
            hi_reg <= hi_calc;
        end
        if (cmd.init_lo) begin
            lo_reg <= SEARCH_W'(1);
        end
        if (cmd.calc_mid) begin
            mid_reg <= mid_calc;
        end
        if (cmd.step) begin
            if (ent_hit) begin
                hi_reg <= mid_reg;
            end else begin
                lo_reg <= mid_reg + SEARCH_W'(1);
            end
        end
        if (cmd.next_size) begin
            s_reg <= s_reg + 3'd1;
        end
        if (cmd.take_ok) begin
            status_reg <= ST_OK;
            spc_reg    <= 7'd1 << s_reg;
            fat_reg    <= 32'(lo_reg);
            clus_reg   <= clus_val[27:0];
            data_reg   <= data_val[31:0];
        end else if (cmd.take_fail) begin
            // no fitting size leaves err_reg at ok
            status_reg <= (err_reg == ST_OK) ? ST_INVALID : err_reg;
            spc_reg    <= 7'd0;
            fat_reg    <= 32'd0;
            clus_reg   <= 28'd0;
            data_reg   <= 32'd0;
        end
    end

    assign res_status = status_reg;
    assign res_spc    = spc_reg;
    assign res_fat    = fat_reg;
    assign res_clus   = clus_reg;
    assign res_data   = data_reg;

endmodule

/* design/fgs_ctrl.sv */
// fgs_ctrl: sequencing state machine of the geometry solver; drives the
// datapath commands and both handshakes. Depends on fgs_pkg.
module fgs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  fgs_pkg::fgs_stat_t stat,
    output fgs_pkg::fgs_cmd_t  cmd
);
    import fgs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SIZE   = 3'd1;
    localparam logic [2:0] S_SKIP   = 3'd2;
    localparam logic [2:0] S_MID    = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       fin_ok_reg, fin_ok_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        fin_ok_next   = fin_ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (stat.pre_status != ST_OK) begin
                        fin_ok_next = 1'b0;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                if (stat.size_fits) begin
                    cmd.calc_hi = 1'b1;
                    state_next  = S_SKIP;
                end else begin
                    fin_ok_next = 1'b0;
                    state_next  = S_FINISH;
                end
            end
            S_SKIP: begin
                if (stat.hi_skip) begin
                    cmd.next_size = 1'b1;
                    state_next    = S_SIZE;
                end else begin
                    cmd.init_lo = 1'b1;
                    state_next  = S_MID;
                end
            end
            S_MID: begin
                if (stat.search_done) begin
                    state_next = S_CHECK;
                end else begin
                    cmd.calc_mid = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP: begin
                cmd.step   = 1'b1;
                state_next = S_MID;
            end
            S_CHECK: begin
                if (stat.clus_ok) begin
                    fin_ok_next = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.next_size = 1'b1;
                    state_next    = S_SIZE;
                end
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.take_ok   = fin_ok_reg;
                    cmd.take_fail = !fin_ok_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fin_ok_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fin_ok_reg   <= fin_ok_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

/* design/fat32_geometry_solver.sv */
// fat32_geometry_solver: top level of the FAT32 volume layout solver.
// Instantiates fgs_ctrl and fgs_datapath; uses fgs_pkg.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+--------
//  s_      | in  | total_sectors 64, bytes_per_sector 16,      | -
//          |     | hidden_count 64                            |
//  m_      | out | cluster_sectors 7, fat_length 32,           | status 2
//          |     | cluster_count 28, data_start 32, pad 5     |
//
// One word in flight. An argument error goes straight to the result. Each
// cluster size tried runs a size check, a skip check, a midpoint and a
// compare step per binary search step (about 26 steps at most, log2 of the
// FAT bound) and a cluster count check; up to all seven sizes run in turn.
// Reset (aresetn low, synchronous) empties the output register and
// returns to idle. A stalled result holds the solver in its finish step;
// a new word is still taken while that result waits.
module fat32_geometry_solver #(
    parameter int unsigned RESERVED_SECTORS  = fgs_pkg::RESERVED_SECTORS_DEF,
    parameter int unsigned MAX_CLUSTER_BYTES = fgs_pkg::MAX_CLUSTER_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request word
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // total_sectors, bytes_per_sector, hidden_count
    // result word
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // cluster_sectors, fat_length, cluster_count,
                                    // data_start, zero pad
    output logic [1:0]   m_tuser    // status
);
    import fgs_pkg::*;

    fgs_cmd_t    cmd;
    fgs_stat_t   stat;
    logic [6:0]  res_spc;
    logic [31:0] res_fat;
    logic [27:0] res_clus;
    logic [31:0] res_data;

    fgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fgs_datapath #(
        .RESERVED_SECTORS  (RESERVED_SECTORS),
        .MAX_CLUSTER_BYTES (MAX_CLUSTER_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .s_total    (s_tdata[63:0]),
        .s_bps      (s_tdata[79:64]),
        .s_hidden   (s_tdata[143:80]),
        .cmd        (cmd),
        .stat       (stat),
        .res_status (m_tuser),
        .res_spc    (res_spc),
        .res_fat    (res_fat),
        .res_clus   (res_clus),
        .res_data   (res_data)
    );

    assign m_tdata = {5'b0, res_data, res_clus, res_fat, res_spc};

    // error results carry no layout
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error result with nonzero layout");

    // data area starts after reserved sectors and both FATs
    a_data_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OK) |->
        ({2'b0, res_data} == (34'(RESERVED_SECTORS) + {1'b0, res_fat, 1'b0})))
        else $error("data_start does not match fat_length");

    // a good layout is always a FAT32-sized one
    a_clus_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OK) |->
        ({4'b0, res_clus} >= MIN_CLUSTERS) && (res_spc != 7'd0))
        else $error("good layout below minimum cluster count");

    // one request at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while solving");

endmodule

/* verif/tb_fat32_geometry_solver.sv */
// tb_fat32_geometry_solver: self-checking testbench for the FAT32 geometry solver.
// Holds its own layout solver, a small scoreboard class and stream drivers.
// Depends on fgs_pkg and fat32_geometry_solver only.
`timescale 1ns / 100ps

module tb_fat32_geometry_solver;
    import fgs_pkg::*;

    localparam longint unsigned RSV_SECTORS   = 64'(RESERVED_SECTORS_DEF);
    localparam longint unsigned CLUSTER_BYTES = 64'(MAX_CLUSTER_BYTES_DEF);
    localparam longint unsigned U32_MAX       = 64'h0000_0000_ffff_ffff;

    // legal sector sizes
    localparam bit [15:0] BPS_512  = 16'd512;
    localparam bit [15:0] BPS_1K   = 16'd1024;
    localparam bit [15:0] BPS_2K   = 16'd2048;
    localparam bit [15:0] BPS_4K   = 16'd4096;

    localparam int N_RANDOM  = 1000;
    localparam int MAX_PRINT = 50;

    // one result word, unpacked into its fields
    typedef struct packed {
        bit [1:0]  status;
        bit [6:0]  cluster_sectors;
        bit [31:0] fat_length;
        bit [27:0] cluster_count;
        bit [31:0] data_start;
    } layout_t;

    // Expected layouts in request order; one result per request.
    class layout_scoreboard;
        layout_t expected_layouts[$];
        int      n_fail;

        function new();
            n_fail = 0;
        endfunction

        // First power-of-two cluster size whose minimal FAT yields a FAT32 count.
        function layout_t solve_layout(bit [63:0] total, bit [15:0] bps, bit [63:0] hidden);
            layout_t         r;
            longint unsigned b, spc, lo, hi, mid, clus_left, entries, data, clus;
            r        = '0;
            r.status = ST_INVALID;
            b        = 64'(bps);
            if (bps != BPS_512 && bps != BPS_1K && bps != BPS_2K && bps != BPS_4K)
                return r;
            if (total <= RSV_SECTORS || total > U32_MAX)
                return r;
            if (hidden > U32_MAX) begin
                r.status = ST_OVERFLOW;
                return r;
            end
            for (spc = 1; spc <= CLUSTER_BYTES / b; spc = spc * 2) begin
                hi = ((total / spc + 2) * 4 + b - 1) / b;
                // even the largest FAT eats the whole volume: try the next size
                if (RSV_SECTORS + 2 * hi >= total)
                    continue;
                lo = 1;
                while (lo < hi) begin
                    mid       = lo + (hi - lo) / 2;
                    clus_left = (total - RSV_SECTORS - 2 * mid) / spc;
                    entries   = mid * b / 4;
                    if (entries >= clus_left + 2)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                data = RSV_SECTORS + 2 * lo;
                clus = (total - data) / spc;
                if (clus < MIN_CLUSTERS || clus > MAX_CLUSTERS)
                    continue;
                r.status          = ST_OK;
                r.cluster_sectors = spc[6:0];
                r.fat_length      = lo[31:0];
                r.cluster_count   = clus[27:0];
                r.data_start      = data[31:0];
                return r;
            end
            return r;
        endfunction

        function void note_request(bit [63:0] total, bit [15:0] bps, bit [63:0] hidden);
            expected_layouts.push_back(solve_layout(total, bps, hidden));
        endfunction

        function int pending();
            return expected_layouts.size();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (n_fail < MAX_PRINT)
                $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
            n_fail++;
        endtask

        task check_layout(logic [1:0] status, logic [103:0] tdata);
            layout_t want;
            if (expected_layouts.size() == 0) begin
                report("unexpected word", {62'd0, status}, 64'd0);
                return;
            end
            want = expected_layouts.pop_front();
            if (status !== want.status)
                report("status", status, want.status);
            if (tdata[6:0] !== want.cluster_sectors)
                report("cluster_sectors", tdata[6:0], want.cluster_sectors);
            if (tdata[38:7] !== want.fat_length)
                report("fat_length", tdata[38:7], want.fat_length);
            if (tdata[66:39] !== want.cluster_count)
                report("cluster_count", tdata[66:39], want.cluster_count);
            if (tdata[98:67] !== want.data_start)
                report("data_start", tdata[98:67], want.data_start);
            if (tdata[103:99] !== 5'd0)
                report("pad", tdata[103:99], 64'd0);
        endtask
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata  = '0;   // total_sectors, bytes_per_sector, hidden_count
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;         // cluster_sectors, fat_length, cluster_count,
                                   // data_start, zero pad
    logic [1:0]   m_tuser;         // status

    layout_scoreboard sb = new();

    fat32_geometry_solver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Offer one request word after `gap` idle cycles and wait for the accept.
    // valid stays high straight into the next word when gap is zero.
    task automatic send_request(input bit [63:0] total, input bit [15:0] bps,
                                input bit [63:0] hidden, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {hidden, bps, total};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_request(total, bps, hidden);
    endtask

    // Drop valid and hold the sender until every result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Result sink. Random stalls, a calm stretch every fourth block of 50 words,
    // and one long hold-off after 60 words so the solver backs up onto s_tready.
    initial begin : result_sink
        int  stall;
        int  seen;
        bit  held;
        stall = 0;
        seen  = 0;
        held  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                sb.check_layout(m_tuser, m_tdata);
                seen++;
            end
            if (stall > 0)
                stall--;
            else if (!held && seen == 60) begin
                held  = 1'b1;
                stall = 400;
            end else if ((seen / 50) % 4 != 1)
                stall = idle_len();
            m_tready <= (stall == 0);
        end
    end

    // Hard stop: well beyond the slowest legal run (~1000 words, each at the
    // slowest solve, plus worst-case gaps on both sides and the long hold-off).
    initial begin : watchdog
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        bit [63:0] total;
        bit [63:0] hidden;
        bit [15:0] bps;
        int        w;
        int        kind;
        int        gap;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        // sector size not one of the four legal values
        send_request(64'd1_000_000, 16'd0,     64'd0, 0);
        send_request(64'd1_000_000, 16'd511,   64'd0, 0);
        send_request(64'd1_000_000, 16'd513,   64'd0, 0);
        send_request(64'd1_000_000, 16'd8192,  64'd0, 1);
        send_request(64'd1_000_000, 16'hffff,  64'd0, 0);
        // sector count at or under the reserved area, or past 32 bits
        send_request(64'd0,                    BPS_512, 64'd0, 0);
        send_request(RSV_SECTORS,              BPS_512, 64'd0, 0);
        send_request(64'h1_0000_0000,          BPS_512, 64'd0, 2);
        send_request(64'hffff_ffff_ffff_ffff,  BPS_4K,  64'd0, 0);
        // just above reserved: every size skipped since the FATs fill the volume
        send_request(RSV_SECTORS + 1,          BPS_512, 64'd0, 0);
        send_request(RSV_SECTORS + 2,          BPS_4K,  64'd0, 0);
        // hidden count limits, and precedence of the argument checks over it
        send_request(64'd500_000,              BPS_512, 64'hffff_ffff, 0);
        send_request(64'd500_000,              BPS_512, 64'h1_0000_0000, 0);
        send_request(64'd500_000,              BPS_1K,  64'hffff_ffff_ffff_ffff, 0);
        send_request(64'd500_000,              16'd100, 64'hffff_ffff_ffff_ffff, 0);
        send_request(64'd10,                   BPS_2K,  64'hffff_ffff_ffff_ffff, 3);
        // each legal sector size with a layout that fits
        send_request(64'd70_000,               BPS_512, 64'd63, 0);
        send_request(64'd4_000_000,            BPS_1K,  64'd2048, 0);
        send_request(64'd80_000_000,           BPS_2K,  64'd0, 0);
        send_request(64'd900_000_000,          BPS_4K,  64'd1, 0);
        // too few clusters at any size, and the largest volume per extreme size
        send_request(64'd65_000,               BPS_512, 64'd0, 0);
        send_request(64'hffff_ffff,            BPS_512, 64'hffff_ffff, 0);
        send_request(64'hffff_ffff,            BPS_4K,  64'd0, 0);
        drain_results();

        // --- random ---
        for (int i = 0; i < N_RANDOM; i++) begin
            kind   = $urandom_range(0, 99);
            bps    = 16'($urandom);
            total  = {$urandom, $urandom};
            hidden = {$urandom, $urandom};
            if (kind < 80 || kind >= 88) begin
                // well-formed size and a sector count spread over all widths
                case ($urandom_range(0, 3))
                    0: bps = BPS_512;
                    1: bps = BPS_1K;
                    2: bps = BPS_2K;
                    default: bps = BPS_4K;
                endcase
                w         = $urandom_range(6, 32);
                total     = total & ((64'd1 << w) - 1);
                total[w-1] = 1'b1;
            end
            if (kind < 80 || (kind >= 80 && kind < 94)) begin
                // hidden within 32 bits, corners now and then
                case ($urandom_range(0, 9))
                    0: hidden = 64'd0;
                    1: hidden = U32_MAX;
                    default: hidden = {32'd0, hidden[31:0]};
                endcase
            end
            if (kind >= 88 && kind < 94) begin
                // sector count out of range: tiny or beyond 32 bits
                if ($urandom_range(0, 1) == 0)
                    total = 64'($urandom_range(0, 32));
                else
                    total[63:32] = total[63:32] | 32'd1 << $urandom_range(0, 31);
            end
            if (kind >= 94)
                hidden[63:32] = hidden[63:32] | 32'd1 << $urandom_range(0, 31);

            // a gap-free stretch every third block of 100 words
            gap = ((i / 100) % 3 == 2) ? 0 : idle_len();
            send_request(total, bps, hidden, gap);
            if (i == N_RANDOM / 2)
                drain_results();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
